// File: rtl/sfr_pkg.sv
// Shared types, constants and step functions of the stuffed frame receiver.
// Depends on nothing; sfr_step, sfr_out_fifo, the top level and the testbench import it.
package sfr_pkg;

   localparam int MAX_FRAME  = 64;
   localparam int BODY_MAX   = MAX_FRAME - 4;
   localparam int CNT_W      = $clog2(BODY_MAX + 1);
   localparam int LCMP_W     = 9;

   localparam logic [7:0] HDR_BYTE = 8'h9d;
   localparam logic [7:0] END_BYTE = 8'hdd;
   localparam logic [7:0] ESC_BYTE = 8'h55;

   localparam logic [1:0] PH_HUNT = 2'd0;
   localparam logic [1:0] PH_ONE  = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_CSUM = 2'd1;
   localparam logic [1:0] ST_LEN  = 2'd2;
   localparam logic [1:0] ST_OVF  = 2'd3;

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [1:0]       phase;
      logic             pend;
      logic             drop;
      logic [7:0]       acc;
      logic [CNT_W-1:0] cnt;
      logic [7:0]       len;
   } state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic [1:0] status;
   } item_type;

   typedef struct packed {
      logic [1:0] n;
      item_type   item0;
      item_type   item1;
   } push_type;

   typedef struct packed {
      state_type st;
      item_type  item;
      logic      ok;
   } keep_type;

   typedef struct packed {
      state_type st;
      item_type  item;
      logic      valid;
   } plain_type;

   typedef struct packed {
      logic [FCNT_W-1:0] count;
      logic              in_ready;
   } fifo_stat_type;

   function automatic state_type hunt_state();
      state_type s;
      s       = '0;
      s.phase = PH_HUNT;
      return s;
   endfunction

   // Keep one body byte, or end the frame with overflow if it is full.
   function automatic keep_type keep_byte(state_type s, logic [7:0] b);
      keep_type k;
      k.st   = s;
      k.item = '0;
      k.ok   = 1'b0;
      if (s.cnt >= CNT_W'(BODY_MAX)) begin
         k.item.frame_end = 1'b1;
         k.item.status    = ST_OVF;
         k.st             = hunt_state();
      end else begin
         k.item.out_byte = b;
         k.st.acc        = s.acc ^ b;
         if (s.cnt == '0) begin
            k.st.len = b;
         end
         k.st.cnt = s.cnt + CNT_W'(1);
         k.ok     = 1'b1;
      end
      return k;
   endfunction

   // Body byte with no 0xdd held.
   function automatic plain_type plain_body(state_type s, logic [7:0] b);
      plain_type p;
      keep_type  k;
      p.st    = s;
      p.item  = '0;
      p.valid = 1'b0;
      k       = '0;
      if (s.drop && b == ESC_BYTE) begin
         p.st.drop = 1'b0;
      end else if (b == END_BYTE) begin
         p.st.drop = 1'b0;
         p.st.pend = 1'b1;
      end else begin
         p.st.drop = 1'b0;
         k         = keep_byte(p.st, b);
         p.st      = k.st;
         p.item    = k.item;
         p.valid   = 1'b1;
         if (k.ok) begin
            p.st.drop = (b == HDR_BYTE) || (b == ESC_BYTE);
         end
      end
      return p;
   endfunction

endpackage

// File: rtl/sfr_req_if.sv
// Input channel of the stuffed frame receiver: raw line byte and gap flag.
// Depends on nothing.
interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       gap_before;

   modport source (output valid, output rx_byte, output gap_before, input ready);
   modport sink   (input valid, input rx_byte, input gap_before, output ready);
endinterface

// File: rtl/sfr_rsp_if.sv
// Result channel of the stuffed frame receiver: body bytes and end status.
// Depends on nothing.
interface sfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       frame_end;
   logic [1:0] status;

   modport source (output valid, output out_byte, output frame_end, output status,
                   input ready);
   modport sink   (input valid, input out_byte, input frame_end, input status,
                   output ready);
endinterface

// File: rtl/sfr_step.sv
// Deframer state register and the per-byte step logic; produces up to two
// result items per transfer. Depends on sfr_pkg.
module sfr_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        rx_byte,
   input  logic              gap_before,
   output sfr_pkg::push_type push
);
   import sfr_pkg::*;

   state_type state_ff;
   state_type state_in;
   state_type s;
   keep_type  k;
   plain_type p;

   always_comb begin
      s    = state_ff;
      k    = '0;
      p    = '0;
      push = '0;
      if (gap_before) begin
         s = hunt_state();
      end
      case (s.phase)
         PH_ONE: begin
            if (rx_byte == HDR_BYTE) begin
               s       = hunt_state();
               s.phase = PH_BODY;
            end else begin
               s.phase = PH_HUNT;
            end
         end
         PH_BODY: begin
            if (s.pend) begin
               s.pend = 1'b0;
               if (rx_byte == END_BYTE) begin
                  push.n                = 2'd1;
                  push.item0.frame_end  = 1'b1;
                  // length error wins over checksum error
                  if (s.cnt < CNT_W'(2) || LCMP_W'(s.cnt) < LCMP_W'(s.len)) begin
                     push.item0.status = ST_LEN;
                  end else if (s.acc != 8'd0) begin
                     push.item0.status = ST_CSUM;
                  end else begin
                     push.item0.status = ST_OK;
                  end
                  s = hunt_state();
               end else begin
                  // held 0xdd turns out to be data
                  s.drop     = 1'b0;
                  k          = keep_byte(s, END_BYTE);
                  s          = k.st;
                  push.n     = 2'd1;
                  push.item0 = k.item;
                  if (k.ok && rx_byte != ESC_BYTE) begin
                     p = plain_body(s, rx_byte);
                     s = p.st;
                     if (p.valid) begin
                        push.n     = 2'd2;
                        push.item1 = p.item;
                     end
                  end
               end
            end else begin
               p = plain_body(s, rx_byte);
               s = p.st;
               if (p.valid) begin
                  push.n     = 2'd1;
                  push.item0 = p.item;
               end
            end
         end
         default: begin
            s.phase = (rx_byte == HDR_BYTE) ? PH_ONE : PH_HUNT;
         end
      endcase
      if (!accept) begin
         push.n = 2'd0;
      end
      state_in = accept ? s : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hunt_state();
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/sfr_out_fifo.sv
// Result queue: takes up to two items per cycle, hands out one per transfer.
// Depends on sfr_pkg.
module sfr_out_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  sfr_pkg::push_type      push,
   input  logic                   pop,
   output sfr_pkg::item_type      head,
   output logic                   head_valid,
   output sfr_pkg::fifo_stat_type stat
);
   import sfr_pkg::*;

   item_type          mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;
   logic [FCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign do_pop     = pop && (count_ff != '0);
   assign head       = mem_ff[rp_ff];
   assign head_valid = (count_ff != '0);

   always_comb begin
      wp_in    = wp_ff + PTR_W'(push.n);
      rp_in    = rp_ff + PTR_W'(do_pop);
      count_in = count_ff + FCNT_W'(push.n) - FCNT_W'(do_pop);
   end

   // room for a two-item push without counting on a pop
   assign stat.in_ready = (count_ff <= FCNT_W'(FIFO_DEPTH - 2));
   assign stat.count    = count_ff;

   always_ff @(posedge clock) begin
      if (push.n != 2'd0) begin
         mem_ff[wp_ff] <= push.item0;
      end
      if (push.n == 2'd2) begin
         mem_ff[wp_ff + PTR_W'(1)] <= push.item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/stuffed_frame_receiver.sv
// Top level of the stuffed frame receiver: step logic plus result queue.
// Depends on sfr_pkg, sfr_req_if, sfr_rsp_if, sfr_step and sfr_out_fifo.
//
// Usage:
//   req_if carries one raw line byte per transfer with a flag that a line
//   silence came before it. rsp_if carries destuffed body bytes and, at the
//   end of each frame not cut by a gap, one status item (frame_end high, out_byte zero).
//   A byte is taken in every cycle while the result queue has room for two
//   items; it updates the deframer state in that cycle and its results
//   (none, one or two) are registered into the queue and appear on rsp_if
//   once the items ahead of them have drained. Throughput is one byte per
//   cycle while the queue has room, set by the single state register update;
//   results drain one per cycle while rsp_if.ready is high from the
//   four-entry queue, so a byte that yields two items takes an extra output transfer.
//   Reset (synchronous) returns the deframer to header hunting and empties
//   the queue. When the sink holds rsp_if.ready low, results wait in the
//   queue and req_if.ready drops once fewer than two entries are free.
module stuffed_frame_receiver (
   input  logic      clock,
   input  logic      reset,
   sfr_req_if.sink   req_if,
   sfr_rsp_if.source rsp_if
);
   import sfr_pkg::*;

   push_type      push;
   item_type      head;
   logic          head_valid;
   fifo_stat_type stat;
   logic          accept;

   assign req_if.ready = stat.in_ready;
   assign accept       = req_if.valid && stat.in_ready;

   sfr_step u_step (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_if.rx_byte),
      .gap_before (req_if.gap_before),
      .push       (push)
   );

   sfr_out_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_if.ready),
      .head       (head),
      .head_valid (head_valid),
      .stat       (stat)
   );

   assign rsp_if.valid     = head_valid;
   assign rsp_if.out_byte  = head.out_byte;
   assign rsp_if.frame_end = head.frame_end;
   assign rsp_if.status    = head.status;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stat.count <= FCNT_W'(FIFO_DEPTH))
      else $error("result queue count beyond depth");

   a_end_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.frame_end) |-> (rsp_if.out_byte == 8'd0))
      else $error("end item with nonzero byte");

   a_body_status_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.frame_end) |-> (rsp_if.status == ST_OK))
      else $error("body item with nonzero status");

   a_push_only_on_accept: assert property (@(posedge clock) disable iff (reset)
      !accept |-> (push.n == 2'd0))
      else $error("results pushed without an input transfer");

   a_idle_count_holds: assert property (@(posedge clock) disable iff (reset)
      (!accept && !rsp_if.ready) |=> $stable(stat.count))
      else $error("queue count moved with no transfer");

endmodule

// File: verif/stuffed_frame_receiver_tb.sv
// Self-checking testbench for stuffed_frame_receiver: random and directed line bytes,
// a scoreboard class that predicts destuffed bytes and end status per transfer.
// Depends on sfr_pkg, sfr_req_if, sfr_rsp_if and the stuffed_frame_receiver RTL.
module stuffed_frame_receiver_tb;
   import sfr_pkg::*;

   class frame_scoreboard;
      logic [1:0]  phase;
      bit          held_end;
      bit          esc_armed;
      logic [7:0]  xsum;
      int unsigned body_len;
      logic [7:0]  len_byte;
      item_type    awaited_items[$];
      int          fail_count;

      function new();
         fail_count = 0;
         restart();
      endfunction

      function void restart();
         phase     = PH_HUNT;
         held_end  = 1'b0;
         esc_armed = 1'b0;
         xsum      = '0;
         body_len  = 0;
         len_byte  = '0;
      endfunction

      function void push_item(logic [7:0] b, logic fe, logic [1:0] st);
         item_type it;
         it.out_byte  = b;
         it.frame_end = fe;
         it.status    = st;
         awaited_items.push_back(it);
      endfunction

      // Returns 0 when the body is full and the frame ended with overflow.
      function bit store_byte(logic [7:0] b);
         if (body_len >= BODY_MAX) begin
            push_item(8'h00, 1'b1, ST_OVF);
            restart();
            return 1'b0;
         end
         push_item(b, 1'b0, ST_OK);
         xsum = xsum ^ b;
         if (body_len == 0) begin
            len_byte = b;
         end
         body_len++;
         return 1'b1;
      endfunction

      function void body_byte(logic [7:0] b);
         if (esc_armed && b == ESC_BYTE) begin
            esc_armed = 1'b0;
            return;
         end
         esc_armed = 1'b0;
         if (b == END_BYTE) begin
            held_end = 1'b1;
            return;
         end
         if (store_byte(b)) begin
            esc_armed = (b == HDR_BYTE) || (b == ESC_BYTE);
         end
      endfunction

      function void close_frame();
         logic [1:0] st;
         if (body_len < 2 || body_len < len_byte) begin
            st = ST_LEN;
         end else if (xsum != 0) begin
            st = ST_CSUM;
         end else begin
            st = ST_OK;
         end
         push_item(8'h00, 1'b1, st);
         restart();
      endfunction

      function void note_byte(logic [7:0] b, logic gap);
         if (gap) begin
            restart();
         end
         case (phase)
            PH_ONE: begin
               if (b == HDR_BYTE) begin
                  restart();
                  phase = PH_BODY;
               end else begin
                  phase = PH_HUNT;
               end
            end
            PH_BODY: begin
               if (held_end) begin
                  held_end = 1'b0;
                  if (b == END_BYTE) begin
                     close_frame();
                  end else if (b == ESC_BYTE) begin
                     esc_armed = 1'b0;
                     void'(store_byte(END_BYTE));
                  end else begin
                     esc_armed = 1'b0;
                     if (store_byte(END_BYTE)) begin
                        body_byte(b);
                     end
                  end
               end else begin
                  body_byte(b);
               end
            end
            default: begin
               phase = (b == HDR_BYTE) ? PH_ONE : PH_HUNT;
            end
         endcase
      endfunction

      function void check_item(item_type got);
         item_type want;
         if (awaited_items.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("unexpected result: out_byte=%h frame_end=%b status=%0d",
                        got.out_byte, got.frame_end, got.status);
            end
            return;
         end
         want = awaited_items.pop_front();
         if (got.out_byte !== want.out_byte || got.frame_end !== want.frame_end ||
             got.status !== want.status) begin
            fail_count++;
            if (fail_count <= 10) begin
               $display("mismatch: want out_byte=%h frame_end=%b status=%0d, got %h %b %0d",
                        want.out_byte, want.frame_end, want.status,
                        got.out_byte, got.frame_end, got.status);
            end
         end
      endfunction

      function int outstanding();
         return awaited_items.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   sfr_req_if req ();
   sfr_rsp_if rsp ();

   frame_scoreboard sb;
   int src_idle_pct;
   int snk_idle_pct;
   int bytes_sent;

   stuffed_frame_receiver dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 400000);
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
   end

   // Results are checked before the input of the same edge is noted.
   always @(posedge clock) begin
      item_type got;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            got.out_byte  = rsp.out_byte;
            got.frame_end = rsp.frame_end;
            got.status    = rsp.status;
            sb.check_item(got);
         end
         if (req.valid && req.ready) begin
            sb.note_byte(req.rx_byte, req.gap_before);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic g);
      while ($urandom_range(99) < src_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid      <= 1'b1;
      req.rx_byte    <= b;
      req.gap_before <= g;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() > 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_special();
      case ($urandom_range(2))
         0:       return HDR_BYTE;
         1:       return END_BYTE;
         default: return ESC_BYTE;
      endcase
   endfunction

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 4);
      repeat (n) begin
         send_byte(($urandom_range(3) == 0) ? pick_special() : 8'($urandom_range(255)),
                   ($urandom_range(3) == 0));
      end
   endtask

   task automatic send_random_frame();
      logic [7:0] body[$];
      logic [7:0] b;
      logic [7:0] x;
      int n;
      int r;
      r = $urandom_range(99);
      if (r < 6) begin
         n = $urandom_range(0, 1);
      end else if (r < 11) begin
         n = $urandom_range(56, 66);
      end else begin
         n = $urandom_range(2, 14);
      end
      x = '0;
      for (int i = 0; i < n; i++) begin
         if (i == 0) begin
            b = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'(n);
         end else if (i == n - 1 && $urandom_range(9) != 0) begin
            b = x;   // check byte: whole body XORs to zero
         end else if ($urandom_range(3) == 0) begin
            b = pick_special();
         end else begin
            b = 8'($urandom_range(255));
         end
         x = x ^ b;
         body.push_back(b);
      end
      if ($urandom_range(3) == 0) begin
         send_noise();
      end
      send_byte(HDR_BYTE, ($urandom_range(7) == 0));
      send_byte(HDR_BYTE, 1'b0);
      foreach (body[i]) begin
         send_byte(body[i], 1'b0);
         if ((body[i] == HDR_BYTE || body[i] == END_BYTE || body[i] == ESC_BYTE) &&
             $urandom_range(19) != 0) begin
            send_byte(ESC_BYTE, 1'b0);
         end
      end
      if ($urandom_range(19) == 0) begin
         // abandon the frame with a silence gap
         send_byte(8'($urandom_range(255)), 1'b1);
      end else begin
         send_byte(END_BYTE, 1'b0);
         send_byte(END_BYTE, 1'b0);
      end
   endtask

   task automatic run_random(input int goal);
      while (bytes_sent < goal) begin
         if ($urandom_range(9) == 0) begin
            send_noise();
         end else begin
            send_random_frame();
         end
      end
   endtask

   initial begin
      sb             = new();
      bytes_sent     = 0;
      src_idle_pct   = 19;
      snk_idle_pct   = 74;
      reset          <= 1'b1;
      req.valid      <= 1'b0;
      req.rx_byte    <= '0;
      req.gap_before <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // noise, then a clean frame with an escaped header byte
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b0);
      send_byte(HDR_BYTE, 1'b0);
      send_byte(HDR_BYTE, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(HDR_BYTE, 1'b0);
      send_byte(ESC_BYTE, 1'b0);
      send_byte(8'h9e, 1'b0);
      send_byte(END_BYTE, 1'b0);
      send_byte(END_BYTE, 1'b0);
      // one-byte body: length error
      send_byte(HDR_BYTE, 1'b0);
      send_byte(HDR_BYTE, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(END_BYTE, 1'b0);
      send_byte(END_BYTE, 1'b0);
      // held end byte followed by plain data, then checksum error
      send_byte(HDR_BYTE, 1'b0);
      send_byte(HDR_BYTE, 1'b0);
      send_byte(8'h02, 1'b0);
      send_byte(END_BYTE, 1'b0);
      send_byte(8'h7e, 1'b0);
      send_byte(END_BYTE, 1'b0);
      send_byte(END_BYTE, 1'b0);
      // gap cuts a frame, a new header follows at once
      send_byte(HDR_BYTE, 1'b0);
      send_byte(HDR_BYTE, 1'b0);
      send_byte(8'h05, 1'b0);
      send_byte(HDR_BYTE, 1'b1);
      send_byte(HDR_BYTE, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(END_BYTE, 1'b0);
      send_byte(END_BYTE, 1'b0);
      wait_drained();

      run_random(bytes_sent + 350);
      wait_drained();
      src_idle_pct = 74;
      snk_idle_pct = 19;
      run_random(bytes_sent + 350);
      src_idle_pct = 0;
      snk_idle_pct = 0;
      run_random(bytes_sent + 350);

      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.fail_count == 0 && sb.outstanding() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// File: filelist.f
rtl/sfr_pkg.sv
rtl/sfr_req_if.sv
rtl/sfr_rsp_if.sv
rtl/sfr_step.sv
rtl/sfr_out_fifo.sv
rtl/stuffed_frame_receiver.sv
verif/stuffed_frame_receiver_tb.sv
